// ===== rtl/core/vtpid_pkg.sv =====
// ----------------------------------------------------------------------------
// vtpid_pkg: shared types and constants for the two-axis visual target PID
// Widths, register indexes, sequencer ops and fixed-point helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package vtpid_pkg;

  localparam int FRAC_BITS_DEF = 8;

  localparam int COORD_W    = 9;
  localparam int D_W        = 10;
  localparam int H_W        = 12;
  localparam int GAIN_W     = 16;
  localparam int BLEND_W    = 9;
  localparam int CMD_W      = 9;
  localparam int OUT_W      = 24;
  localparam int ERR_W      = 24;
  localparam int INTEG_W    = 32;
  localparam int SUM_W      = 35;
  localparam int ACC_W      = 48;
  localparam int MA_W       = 35;
  localparam int MB_W       = 17;
  localparam int PROD_W     = MA_W + MB_W;
  localparam int WIDE_W     = 56;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [MB_W-1:0]    SMOOTH_NEW = MB_W'(77);
  localparam logic [MB_W-1:0]    SMOOTH_OLD = MB_W'(179);
  localparam logic [BLEND_W-1:0] BLEND_ONE  = BLEND_W'(256);
  localparam logic [COORD_W-1:0] CENTER_X_RST = COORD_W'(160);
  localparam logic [COORD_W-1:0] CENTER_Y_RST = COORD_W'(128);
  localparam int CMD_LIMIT   = 150;
  localparam int INTEG_LIMIT = 10;
  localparam int RND_BLEND   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND    = 3'd5;

  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef enum logic [3:0] {
    OP_ERR,
    OP_CMD,
    OP_DNEW,
    OP_DOLD,
    OP_INT,
    OP_PROP,
    OP_DER,
    OP_HOLD,
    OP_BLEND
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic issue;
    op_t  iop;
    logic wb;
    op_t  wop;
    logic axis;
  } ctl_t;

  function automatic wide_t sat_wide(input wide_t v, input int unsigned bits);
    wide_t lim;
    lim = wide_t'(1) << (bits - 1);
    if (v > lim - wide_t'(1)) begin
      return lim - wide_t'(1);
    end else if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  // add half, then floor
  function automatic wide_t rnd_shr(input wide_t v, input int unsigned s);
    return (v + (wide_t'(1) << (s - 1))) >>> s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/visual_target_pid_two_axis_top.sv =====
// ----------------------------------------------------------------------------
// visual_target_pid_two_axis_top: two-axis visual target PID controller
// Per-axis PID on pixel offset times height, with a smoothed derivative,
// a clamped integrator, output blending and a clamped proportional command.
//
// Usage:
//   Input channel (in_*): one request per camera frame, valid/stall.
//   Result channel (out_*): one result per request, valid/stall.
//   Config channel (cfg_*): valid/ready write of register cfg_index, always
//   ready; write only while no request is in flight.
//   Each request runs, from acceptance to the next acceptance, through the
//   accepting cycle, nine products per axis through one shared multiplier,
//   one write-back slot per axis and one load into the output register.
//   The result shows on out_valid once loaded into the output register.
//   The output register holds a finished result while the receiver stalls;
//   a new request is still taken, and a second result waits in the core
//   until the register frees.
//   Reset restores register defaults and clears the per-axis error, derivative, integrator and output history.
// ----------------------------------------------------------------------------
`default_nettype none

module visual_target_pid_two_axis_top import vtpid_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [COORD_W-1:0]      in_target_x,
  input  logic [COORD_W-1:0]      in_target_y,
  input  logic                    in_detected,
  input  logic [H_W-1:0]          in_height,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_pid_x,
  output logic signed [OUT_W-1:0] out_pid_y,
  output logic signed [CMD_W-1:0] out_cmd_x,
  output logic signed [CMD_W-1:0] out_cmd_y,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  logic [COORD_W-1:0] center_x_r, center_y_r;
  logic [GAIN_W-1:0]  gain_p_r, gain_i_r, gain_d_r;
  logic [BLEND_W-1:0] blend_r;
  logic [BLEND_W-1:0] bl;

  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_pid_x_r, out_pid_y_r;
  logic signed [CMD_W-1:0] out_cmd_x_r, out_cmd_y_r;

  ctl_t                    ctl;
  logic                    load_out;
  logic signed [OUT_W-1:0] pid_x, pid_y;
  logic signed [CMD_W-1:0] cmd_x, cmd_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= CENTER_X_RST;
      center_y_r <= CENTER_Y_RST;
      gain_p_r   <= '0;
      gain_i_r   <= '0;
      gain_d_r   <= '0;
      blend_r    <= BLEND_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CENTER_X: center_x_r <= cfg_data[COORD_W-1:0];
        CFG_CENTER_Y: center_y_r <= cfg_data[COORD_W-1:0];
        CFG_GAIN_P:   gain_p_r   <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:   gain_i_r   <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:   gain_d_r   <= cfg_data[GAIN_W-1:0];
        CFG_BLEND:    blend_r    <= cfg_data[BLEND_W-1:0];
        default: ;
      endcase
    end
  end

  assign bl = (blend_r > BLEND_ONE) ? BLEND_ONE : blend_r;

  vtpid_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_valid (out_valid_r),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .load_out  (load_out),
    .ctl       (ctl)
  );

  vtpid_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .target_x (in_target_x),
    .target_y (in_target_y),
    .detected (in_detected),
    .height   (in_height),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .gain_p   (gain_p_r),
    .gain_i   (gain_i_r),
    .gain_d   (gain_d_r),
    .bl       (bl),
    .pid_x    (pid_x),
    .pid_y    (pid_y),
    .cmd_x    (cmd_x),
    .cmd_y    (cmd_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pid_x_r <= pid_x;
      out_pid_y_r <= pid_y;
      out_cmd_x_r <= cmd_x;
      out_cmd_y_r <= cmd_y;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pid_x = out_pid_x_r;
  assign out_pid_y = out_pid_y_r;
  assign out_cmd_x = out_cmd_x_r;
  assign out_cmd_y = out_cmd_y_r;

endmodule

`default_nettype wire

// ===== rtl/core/vtpid_mul.sv =====
// ----------------------------------------------------------------------------
// vtpid_mul: shared signed multiplier
// One signed product per cycle while en is high, registered at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpid_mul import vtpid_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [MA_W-1:0]   a,
  input  logic signed [MB_W-1:0]   b,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(a) * PROD_W'(b);
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// ===== rtl/core/vtpid_seq.sv =====
// ----------------------------------------------------------------------------
// vtpid_seq: step sequencer
// Walks the op list once per axis, with one write-back slot behind each issue.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpid_seq import vtpid_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic out_valid,
  input  logic out_stall,
  output logic in_stall,
  output logic load_out,
  output ctl_t ctl
);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  op_t    wop_r, wop_nxt;
  logic   axis_r, axis_nxt;
  logic   wb_r, wb_nxt;
  logic   issue;
  logic   load_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_ERR;
      wop_r   <= OP_ERR;
      axis_r  <= 1'b0;
      wb_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      wop_r   <= wop_nxt;
      axis_r  <= axis_nxt;
      wb_r    <= wb_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    wop_nxt   = op_r;
    axis_nxt  = axis_r;
    wb_nxt    = 1'b0;
    issue     = 1'b0;
    load_in   = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          load_in   = 1'b1;
          state_nxt = ST_RUN;
          op_nxt    = OP_ERR;
          axis_nxt  = 1'b0;
        end
      end
      ST_RUN: begin
        issue  = 1'b1;
        wb_nxt = 1'b1;
        if (op_r == OP_BLEND) begin
          state_nxt = ST_DRAIN;
        end else begin
          op_nxt = op_t'(op_r + 4'd1);
        end
      end
      ST_DRAIN: begin
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          op_nxt    = OP_ERR;
          state_nxt = ST_RUN;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign ctl.load_in = load_in;
  assign ctl.issue   = issue;
  assign ctl.iop     = op_r;
  assign ctl.wb      = wb_r;
  assign ctl.wop     = wop_r;
  assign ctl.axis    = axis_r;

endmodule

`default_nettype wire

// ===== rtl/core/vtpid_dp.sv =====
// ----------------------------------------------------------------------------
// vtpid_dp: PID datapath
// Operand select into the shared multiplier, write-back and per-axis state.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpid_dp import vtpid_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctl_t                     ctl,
  input  logic [COORD_W-1:0]       target_x,
  input  logic [COORD_W-1:0]       target_y,
  input  logic                     detected,
  input  logic [H_W-1:0]           height,
  input  logic [COORD_W-1:0]       center_x,
  input  logic [COORD_W-1:0]       center_y,
  input  logic [GAIN_W-1:0]        gain_p,
  input  logic [GAIN_W-1:0]        gain_i,
  input  logic [GAIN_W-1:0]        gain_d,
  input  logic [BLEND_W-1:0]       bl,
  output logic signed [OUT_W-1:0]  pid_x,
  output logic signed [OUT_W-1:0]  pid_y,
  output logic signed [CMD_W-1:0]  cmd_x,
  output logic signed [CMD_W-1:0]  cmd_y
);

  localparam wide_t I_LIM = wide_t'(INTEG_LIMIT) << FRAC_BITS;
  localparam wide_t C_LIM = wide_t'(CMD_LIMIT);

  logic signed [D_W-1:0]     d_r [2];
  logic [H_W-1:0]            h_r;
  logic                      det_r;
  logic signed [ERR_W-1:0]   diff_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [CMD_W-1:0]   cmd_r [2];
  logic signed [ERR_W-1:0]   prev_err_r [2];
  logic signed [ERR_W-1:0]   prev_d_r [2];
  logic signed [INTEG_W-1:0] integ_r [2];
  logic signed [OUT_W-1:0]   prev_out_r [2];

  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [BLEND_W-1:0]        hold_w;
  logic                      ax;

  wide_t prodw, accw, rf, acc_rnd, integ_base, integ_new, iw, icl, cmd_w;
  logic signed [CMD_W-1:0]   cmd_val;

  assign ax     = ctl.axis;
  assign hold_w = BLEND_ONE - bl;

  vtpid_mul u_mul (
    .clk  (clk),
    .en   (ctl.issue),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.iop)
      OP_ERR: begin
        mul_a = MA_W'(d_r[ax]);
        mul_b = MB_W'(h_r);
      end
      OP_CMD: begin
        mul_a = MA_W'(d_r[ax]);
        mul_b = MB_W'(gain_p);
      end
      OP_DNEW: begin
        mul_a = MA_W'(diff_r);
        mul_b = SMOOTH_NEW;
      end
      OP_DOLD: begin
        mul_a = MA_W'(prev_d_r[ax]);
        mul_b = SMOOTH_OLD;
      end
      OP_INT: begin
        mul_a = MA_W'(prev_err_r[ax]);
        mul_b = MB_W'(gain_i);
      end
      OP_PROP: begin
        mul_a = MA_W'(prev_err_r[ax]);
        mul_b = MB_W'(gain_p);
      end
      OP_DER: begin
        mul_a = MA_W'(prev_d_r[ax]);
        mul_b = MB_W'(gain_d);
      end
      OP_HOLD: begin
        mul_a = MA_W'(prev_out_r[ax]);
        mul_b = MB_W'(hold_w);
      end
      OP_BLEND: begin
        mul_a = sum_r;
        mul_b = MB_W'(bl);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    prodw      = wide_t'(prod);
    accw       = wide_t'(acc_r);
    rf         = rnd_shr(prodw, FRAC_BITS);
    acc_rnd    = rnd_shr(accw + prodw, RND_BLEND);
    integ_base = (gain_i == '0) ? '0 : wide_t'(integ_r[ax]);
    integ_new  = sat_wide(integ_base + rf, INTEG_W);
    iw         = wide_t'(integ_r[ax]);
    if (iw > I_LIM) begin
      icl = I_LIM;
    end else if (iw < -I_LIM) begin
      icl = -I_LIM;
    end else begin
      icl = iw;
    end
    if (rf > C_LIM) begin
      cmd_w = C_LIM;
    end else if (rf < -C_LIM) begin
      cmd_w = -C_LIM;
    end else begin
      cmd_w = rf;
    end
    if (!det_r) begin
      cmd_val = '0;
    end else if (ax) begin
      cmd_val = CMD_W'(-cmd_w);
    end else begin
      cmd_val = CMD_W'(cmd_w);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      d_r[0] <= $signed({1'b0, target_x}) - $signed({1'b0, center_x});
      d_r[1] <= $signed({1'b0, target_y}) - $signed({1'b0, center_y});
      h_r    <= height;
      det_r  <= detected;
    end
    if (ctl.wb) begin
      case (ctl.wop)
        OP_ERR:  diff_r  <= ERR_W'(prodw - wide_t'(prev_err_r[ax]));
        OP_CMD:  cmd_r[ax] <= cmd_val;
        OP_DNEW: acc_r   <= ACC_W'(prodw);
        OP_PROP: acc_r   <= ACC_W'(rf + icl);
        OP_DER:  sum_r   <= SUM_W'(sat_wide(accw + rf, SUM_W));
        OP_HOLD: acc_r   <= ACC_W'(prodw);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 2; k++) begin
        prev_err_r[k] <= '0;
        prev_d_r[k]   <= '0;
        integ_r[k]    <= '0;
        prev_out_r[k] <= '0;
      end
    end else if (ctl.wb) begin
      case (ctl.wop)
        OP_ERR:   prev_err_r[ax] <= ERR_W'(prodw);
        OP_DOLD:  prev_d_r[ax]   <= ERR_W'(sat_wide(acc_rnd, ERR_W));
        OP_INT:   integ_r[ax]    <= INTEG_W'(integ_new);
        OP_BLEND: prev_out_r[ax] <= OUT_W'(sat_wide(acc_rnd, OUT_W));
        default: ;
      endcase
    end
  end

  assign pid_x = prev_out_r[0];
  assign pid_y = prev_out_r[1];
  assign cmd_x = cmd_r[0];
  assign cmd_y = cmd_r[1];

endmodule

`default_nettype wire

// ===== rtl/core/vtpid_chk.sv =====
// ----------------------------------------------------------------------------
// vtpid_chk: port-level checker for the two-axis visual target PID
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpid_chk import vtpid_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [OUT_W-1:0] out_pid_x,
  input logic signed [OUT_W-1:0] out_pid_y,
  input logic signed [CMD_W-1:0] out_cmd_x,
  input logic signed [CMD_W-1:0] out_cmd_y
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while busy");

  a_free_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("not ready when result issued");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_pid_x) && $stable(out_pid_y)
                                  && $stable(out_cmd_x) && $stable(out_cmd_y)))
    else $error("stalled result changed");

  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cmd_x >= -CMD_LIMIT && out_cmd_x <= CMD_LIMIT
                   && out_cmd_y >= -CMD_LIMIT && out_cmd_y <= CMD_LIMIT))
    else $error("command out of range");

endmodule

bind visual_target_pid_two_axis_top vtpid_chk u_vtpid_chk (.*);

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: regression bench for the two-axis visual target PID
// Sends camera requests and register writes to the block and predicts each
// result with a fixed-point model of both PID axes and the proportional
// command. Every result is compared field by field with the oldest
// prediction. Idle and stall rates on both channels change between phases.
// ----------------------------------------------------------------------------
module tb;
  import vtpid_pkg::*;

  localparam int FRAC          = FRAC_BITS_DEF;
  localparam int N_RANDOM      = 1080;
  localparam int N_SEGMENTS    = 6;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct {
    logic [COORD_W-1:0] tx;
    logic [COORD_W-1:0] ty;
    logic               det;
    logic [H_W-1:0]     h;
  } aim_req_t;

  typedef struct {
    logic signed [OUT_W-1:0] pid_x;
    logic signed [OUT_W-1:0] pid_y;
    logic signed [CMD_W-1:0] cmd_x;
    logic signed [CMD_W-1:0] cmd_y;
  } aim_res_t;

  class aim_scoreboard;
    logic [COORD_W-1:0]        center_x, center_y;
    logic [GAIN_W-1:0]         gain_p, gain_i, gain_d;
    logic [BLEND_W-1:0]        blend;
    logic signed [ERR_W-1:0]   err_last [2];
    logic signed [ERR_W-1:0]   deriv_last [2];
    logic signed [INTEG_W-1:0] integ [2];
    logic signed [OUT_W-1:0]   out_last [2];
    aim_res_t                  due [$];
    int                        errors;

    function new();
      center_x = CENTER_X_RST;
      center_y = CENTER_Y_RST;
      gain_p   = '0;
      gain_i   = '0;
      gain_d   = '0;
      blend    = BLEND_ONE;
      for (int k = 0; k < 2; k++) begin
        err_last[k]   = '0;
        deriv_last[k] = '0;
        integ[k]      = '0;
        out_last[k]   = '0;
      end
      errors = 0;
    endfunction

    // add half, then floor
    function longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function longint saturate(longint v, int bits);
      longint lim;
      lim = longint'(1) << (bits - 1);
      return clamp(v, -lim, lim - 1);
    endfunction

    function longint axis_pid_step(int k, longint e, longint bl);
      longint deriv, ilim, sum, res;
      ilim  = longint'(INTEG_LIMIT) << FRAC;
      deriv = saturate(round_shift(longint'(SMOOTH_NEW) * (e - longint'(err_last[k]))
                                   + longint'(SMOOTH_OLD) * longint'(deriv_last[k]), 8),
                       ERR_W);
      err_last[k]   = ERR_W'(saturate(e, ERR_W));
      deriv_last[k] = ERR_W'(deriv);
      if (gain_i == '0) integ[k] = '0;
      integ[k] = INTEG_W'(saturate(longint'(integ[k])
                                   + round_shift(e * longint'(gain_i), FRAC), INTEG_W));
      sum = round_shift(e * longint'(gain_p), FRAC)
          + round_shift(deriv * longint'(gain_d), FRAC)
          + clamp(longint'(integ[k]), -ilim, ilim);
      res = saturate(round_shift(bl * sum + (longint'(BLEND_ONE) - bl) * longint'(out_last[k]),
                                 RND_BLEND), OUT_W);
      out_last[k] = OUT_W'(res);
      return res;
    endfunction

    function longint prop_cmd(longint d);
      return clamp(round_shift(d * longint'(gain_p), FRAC), -CMD_LIMIT, CMD_LIMIT);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CENTER_X: center_x = data[COORD_W-1:0];
        CFG_CENTER_Y: center_y = data[COORD_W-1:0];
        CFG_GAIN_P:   gain_p   = data[GAIN_W-1:0];
        CFG_GAIN_I:   gain_i   = data[GAIN_W-1:0];
        CFG_GAIN_D:   gain_d   = data[GAIN_W-1:0];
        CFG_BLEND:    blend    = data[BLEND_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_request(aim_req_t r);
      longint   dx, dy, bl;
      aim_res_t x;
      dx = longint'(r.tx) - longint'(center_x);
      dy = longint'(r.ty) - longint'(center_y);
      bl = (blend > BLEND_ONE) ? longint'(BLEND_ONE) : longint'(blend);
      x.pid_x = OUT_W'(axis_pid_step(0, dx * longint'(r.h), bl));
      x.pid_y = OUT_W'(axis_pid_step(1, dy * longint'(r.h), bl));
      if (r.det) begin
        x.cmd_x = CMD_W'(prop_cmd(dx));
        x.cmd_y = CMD_W'(-prop_cmd(dy));
      end else begin
        x.cmd_x = '0;
        x.cmd_y = '0;
      end
      due.push_back(x);
    endfunction

    function void compare_field(string field, longint want, longint got);
      if (want != got) begin
        $display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(aim_res_t got);
      aim_res_t want;
      if (due.size() == 0) begin
        $display("%0t unexpected result: expected none actual pid_x %0d pid_y %0d",
                 $time, got.pid_x, got.pid_y);
        errors++;
        return;
      end
      want = due.pop_front();
      compare_field("pid_x", want.pid_x, got.pid_x);
      compare_field("pid_y", want.pid_y, got.pid_y);
      compare_field("cmd_x", want.cmd_x, got.cmd_x);
      compare_field("cmd_y", want.cmd_y, got.cmd_y);
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    in_valid    = 1'b0;
  logic                    in_stall;
  logic [COORD_W-1:0]      in_target_x = '0;
  logic [COORD_W-1:0]      in_target_y = '0;
  logic                    in_detected = 1'b0;
  logic [H_W-1:0]          in_height   = '0;
  logic                    out_valid;
  logic                    out_stall   = 1'b0;
  logic signed [OUT_W-1:0] out_pid_x;
  logic signed [OUT_W-1:0] out_pid_y;
  logic signed [CMD_W-1:0] out_cmd_x;
  logic signed [CMD_W-1:0] out_cmd_y;
  logic                    cfg_valid   = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index   = '0;
  logic [CFG_DATA_W-1:0]   cfg_data    = '0;

  int            in_idle_pct  = 0;
  int            out_idle_pct = 0;
  int            quiet_cycles = 0;
  aim_req_t      last_req     = '{default: '0};
  aim_scoreboard sb           = new;

  always #5 clk = ~clk;

  visual_target_pid_two_axis_top #(
    .FRAC_BITS (FRAC)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_target_x (in_target_x),
    .in_target_y (in_target_y),
    .in_detected (in_detected),
    .in_height   (in_height),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_pid_x   (out_pid_x),
    .out_pid_y   (out_pid_y),
    .out_cmd_x   (out_cmd_x),
    .out_cmd_y   (out_cmd_y),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_idle_pct);
  end

  always @(posedge clk) begin
    aim_req_t req_seen;
    aim_res_t res_seen;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (out_valid && !out_stall) begin
        res_seen.pid_x = out_pid_x;
        res_seen.pid_y = out_pid_y;
        res_seen.cmd_x = out_cmd_x;
        res_seen.cmd_y = out_cmd_y;
        sb.check_result(res_seen);
      end
      if (in_valid && !in_stall) begin
        req_seen.tx  = in_target_x;
        req_seen.ty  = in_target_y;
        req_seen.det = in_detected;
        req_seen.h   = in_height;
        sb.take_request(req_seen);
      end
      if ((cfg_valid && cfg_ready) || (out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t no handshake for %0d cycles", $time, quiet_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [COORD_W-1:0] tx, input logic [COORD_W-1:0] ty,
                              input logic det, input logic [H_W-1:0] h);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_target_x <= tx;
    in_target_y <= ty;
    in_detected <= det;
    in_height   <= h;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg_req(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] cy,
                              input logic [CFG_DATA_W-1:0] gp, input logic [CFG_DATA_W-1:0] gi,
                              input logic [CFG_DATA_W-1:0] gd, input logic [CFG_DATA_W-1:0] bl);
    write_reg_req(CFG_CENTER_X, cx);
    write_reg_req(CFG_CENTER_Y, cy);
    write_reg_req(CFG_GAIN_P, gp);
    write_reg_req(CFG_GAIN_I, gi);
    write_reg_req(CFG_GAIN_D, gd);
    write_reg_req(CFG_BLEND, bl);
    write_reg_req(CFG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg_req(CFG_SPARE_HI, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // drop valid and hold until every predicted result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(0, 16'h0200));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_center(int hi, int rst_val);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return CFG_DATA_W'(rst_val);
      default: return CFG_DATA_W'($urandom_range(0, hi));
    endcase
  endfunction

  task automatic random_config();
    logic [CFG_DATA_W-1:0] bl;
    case ($urandom_range(0, 7))
      0:       bl = '0;
      1:       bl = CFG_DATA_W'(BLEND_ONE);
      2:       bl = '1;
      3:       bl = CFG_DATA_W'($urandom_range(257, 511));
      default: bl = CFG_DATA_W'($urandom_range(0, 256));
    endcase
    program_regs(pick_center(320, CENTER_X_RST), pick_center(256, CENTER_Y_RST),
                 pick_gain(), pick_gain(), pick_gain(), bl);
  endtask

  // a third of requests track the last position with jitter, the rest take a fresh one
  task automatic random_request();
    aim_req_t r;
    if ($urandom_range(0, 2) == 0) begin
      r    = last_req;
      r.tx = r.tx + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
      r.ty = r.ty + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
    end else begin
      r.tx = ($urandom_range(0, 9) == 0) ? COORD_W'($urandom) : COORD_W'($urandom_range(0, 320));
      r.ty = ($urandom_range(0, 9) == 0) ? COORD_W'($urandom) : COORD_W'($urandom_range(0, 256));
    end
    r.det = ($urandom_range(0, 3) != 0);
    r.h   = ($urandom_range(0, 9) == 0) ? H_W'($urandom) : H_W'($urandom_range(0, 2560));
    send_request(r.tx, r.ty, r.det, r.h);
    last_req = r;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    in_idle_pct  = 13;
    out_idle_pct = 68;

    send_request(9'd0, 9'd0, 1'b1, 12'd0);
    send_request(9'd511, 9'd511, 1'b1, 12'd4095);
    send_request(9'd320, 9'd256, 1'b0, 12'd2560);
    settle();

    // saturate integrators, derivative and outputs; blend above one
    program_regs('0, '1, '1, '1, '1, '1);
    repeat (4) send_request(9'd511, 9'd0, 1'b1, 12'd4095);
    repeat (2) send_request(9'd0, 9'd511, 1'b1, 12'd4095);
    send_request(9'd511, 9'd0, 1'b0, 12'd4095);
    settle();

    // zero blend holds the last output, zero integral gain clears the integrators
    program_regs(16'd320, 16'd256, 16'd1, '0, '0, '0);
    send_request(9'd0, 9'd0, 1'b1, 12'd2560);
    send_request(9'd511, 9'd511, 1'b0, 12'd4095);
    settle();

    program_regs(16'd160, 16'd128, 16'h0100, 16'h0001, 16'h0080, 16'h0080);
    send_request(9'd161, 9'd127, 1'b1, 12'd256);
    send_request(9'd160, 9'd128, 1'b0, 12'd1);
    send_request(9'd0, 9'd256, 1'b1, 12'd2560);
    send_request(9'd320, 9'd0, 1'b1, 12'd2560);
    send_request(9'd257, 9'd300, 1'b1, 12'd2048);
    settle();

    for (int seg = 0; seg < N_SEGMENTS; seg++) begin
      in_idle_pct  = (seg < 2) ? 13 : (seg < 4) ? 68 : 0;
      out_idle_pct = (seg < 2) ? 68 : (seg < 4) ? 13 : 0;
      random_config();
      repeat (N_RANDOM / N_SEGMENTS) random_request();
      settle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
